// ===== design/rcfd_pkg.sv =====
// Shared types and constants for the receiver frame decoder.
`default_nettype none

package rcfd_pkg;

    // Frame storage and byte counting
    localparam int STORE_DEPTH     = 25;
    localparam int STORE_IDX_W     = $clog2(STORE_DEPTH);
    localparam int MAX_FRAME_BYTES = 36;
    localparam int COUNT_W         = 6;
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
    localparam logic [COUNT_W-1:0] SBUS_LEN  = 6'd25;
    localparam logic [7:0]         SBUS_HEAD = 8'h0F;
    localparam logic [7:0]         SBUS_TAIL = 8'h00;

    // Result items
    localparam int MAX_RESULTS  = 13;
    localparam int SBUS_RESULTS = 10;
    localparam int REM_W        = 4;
    localparam int VALUE_W      = 17;
    localparam int ID_W         = 5;
    localparam logic [REM_W-1:0] REM_SBUS = 4'd10;
    localparam logic [REM_W-1:0] REM_EXT  = 4'd13;
    localparam logic [ID_W-1:0]  ID_SBUS_ZERO_LAST = 5'd4;
    localparam logic [ID_W-1:0]  ID_SWITCH_1       = 5'd10;
    localparam logic [ID_W-1:0]  ID_SWITCH_2       = 5'd11;
    localparam logic FMT_SBUS = 1'b0;
    localparam logic FMT_EXT  = 1'b1;

    // Configuration port
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 11;
    localparam logic [CFG_ADDR_W-1:0] REG_FRAME_LENGTH = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_DEADBAND     = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_SBUS_LIMIT   = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_EXT_LIMIT    = 2'd3;

    typedef logic [STORE_DEPTH-1:0][7:0] store_t;
    typedef logic signed [VALUE_W-1:0]   value_t;

    typedef struct packed {
        logic [COUNT_W-1:0] frame_length;
        logic [10:0]        deadband;
        logic [10:0]        sbus_limit;
        logic [10:0]        ext_limit;
    } cfg_t;

    // Completed frame waiting to be decoded
    typedef struct packed {
        logic valid;
        logic sbus_len;
    } frame_done_t;

    // One decoded frame, items in output order
    typedef struct packed {
        value_t [MAX_RESULTS-1:0]           value;
        logic   [MAX_RESULTS-1:0][ID_W-1:0] id;
        logic                               fmt;
        logic                               err;
        logic   [REM_W-1:0]                 count;
    } decoded_t;

endpackage

`default_nettype wire

// ===== design/rcfd_cfg_regs.sv =====
// Configuration register file for the receiver frame decoder.
`default_nettype none

module rcfd_cfg_regs (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            wr_en,
    input  logic [rcfd_pkg::CFG_ADDR_W-1:0] wr_addr,
    input  logic [rcfd_pkg::CFG_DATA_W-1:0] wr_data,
    output rcfd_pkg::cfg_t                  cfg
);
    import rcfd_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Decode the register index and update one field
    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            unique case (wr_addr)
                REG_FRAME_LENGTH: cfg_next.frame_length = wr_data[COUNT_W-1:0];
                REG_DEADBAND:     cfg_next.deadband     = wr_data;
                REG_SBUS_LIMIT:   cfg_next.sbus_limit   = wr_data;
                REG_EXT_LIMIT:    cfg_next.ext_limit    = wr_data;
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.frame_length <= 6'd25;
            cfg_reg.deadband     <= 11'd30;
            cfg_reg.sbus_limit   <= 11'd1024;
            cfg_reg.ext_limit    <= 11'd660;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// ===== design/rcfd_capture.sv =====
// Byte capture: frame store, saturating byte count and frame-complete flag.
`default_nettype none

module rcfd_capture (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [7:0]                   in_byte,
    input  logic                         in_end,
    input  logic [rcfd_pkg::COUNT_W-1:0] frame_length,
    input  logic                         emit_idle,
    output rcfd_pkg::store_t             store,
    output rcfd_pkg::frame_done_t        done
);
    import rcfd_pkg::*;

    store_t             store_reg;
    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;
    logic [COUNT_W-1:0] count_inc;
    frame_done_t        done_reg;
    frame_done_t        done_next;
    logic               accept;
    logic               frame_match;

    // Hold input while a finished frame cannot yet be handed to the emitter
    assign in_ready = !(done_reg.valid && !emit_idle);
    assign accept   = in_valid && in_ready;

    assign count_inc   = (count_reg == COUNT_MAX) ? count_reg : count_reg + 1'b1;
    assign frame_match = (count_inc == frame_length) &&
                         (count_inc <= COUNT_W'(MAX_FRAME_BYTES));

    // Advance the count; restart it at every end of frame
    always_comb begin
        count_next = count_reg;
        done_next  = done_reg;
        if (done_reg.valid && emit_idle) begin
            done_next.valid = 1'b0;
        end
        if (accept) begin
            count_next = in_end ? '0 : count_inc;
            if (in_end && frame_match) begin
                done_next.valid    = 1'b1;
                done_next.sbus_len = (count_inc == SBUS_LEN);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            done_reg  <= '0;
        end else begin
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    // Store the first bytes of the frame; later bytes are only counted
    always_ff @(posedge aclk) begin
        if (accept && (count_reg < COUNT_W'(STORE_DEPTH))) begin
            store_reg[count_reg[STORE_IDX_W-1:0]] <= in_byte;
        end
    end

    assign store = store_reg;
    assign done  = done_reg;

endmodule

`default_nettype wire

// ===== design/rcfd_decode.sv =====
// Frame decode: unpacks a stored frame into its list of result items.
`default_nettype none

module rcfd_decode (
    input  rcfd_pkg::store_t     store,
    input  logic                 sbus_len,
    input  rcfd_pkg::cfg_t       cfg,
    output rcfd_pkg::decoded_t   dec
);
    import rcfd_pkg::*;

    // Magnitude of a 12-bit signed channel; -1024 gives 1024
    function automatic logic [10:0] chan_mag(input logic [11:0] v);
        logic [11:0] a;
        a = v[11] ? (~v + 12'd1) : v;
        return a[10:0];
    endfunction

    function automatic value_t sext12(input logic [11:0] v);
        return {{(VALUE_W-12){v[11]}}, v};
    endfunction

    function automatic value_t sext16(input logic [15:0] v);
        return {v[15], v};
    endfunction

    logic [10:0]      sraw [SBUS_RESULTS];
    logic [11:0]      sch  [SBUS_RESULTS];
    logic [10:0]      sbus_mag [4];
    logic             sbus_err;
    logic             is_sbus;
    logic [10:0]      eraw [4];
    logic [11:0]      ech  [4];
    logic [15:0]      ech4;
    logic [1:0]       sw1;
    logic [1:0]       sw2;
    logic             ext_err;

    assign is_sbus = sbus_len && (store[0] == SBUS_HEAD) &&
                     (store[STORE_DEPTH-1] == SBUS_TAIL);

    // SBUS: ten 11-bit channels from bytes 1 to 14
    assign sraw[0] = {store[2][2:0], store[1]};
    assign sraw[1] = {store[3][5:0], store[2][7:3]};
    assign sraw[2] = {store[5][0], store[4], store[3][7:6]};
    assign sraw[3] = {store[6][3:0], store[5][7:1]};
    assign sraw[4] = {store[7][6:0], store[6][7:4]};
    assign sraw[5] = {store[9][1:0], store[8], store[7][7]};
    assign sraw[6] = {store[10][4:0], store[9][7:2]};
    assign sraw[7] = {store[11], store[10][7:5]};
    assign sraw[8] = {store[13][2:0], store[12]};
    assign sraw[9] = {store[14][5:0], store[13][7:3]};

    always_comb begin
        sbus_err = 1'b0;
        for (int i = 0; i < SBUS_RESULTS; i++) begin
            sch[i] = (i < 4) ? ({1'b0, sraw[i]} - 12'd1024) : ({1'b0, sraw[i]} - 12'd240);
        end
        for (int i = 0; i < 4; i++) begin
            sbus_mag[i] = chan_mag(sch[i]);
            if (sbus_mag[i] > cfg.sbus_limit) begin
                sbus_err = 1'b1;
            end
        end
    end

    // 18-byte format: four sticks, switches and the range check
    assign eraw[0] = {store[1][2:0], store[0]};
    assign eraw[1] = {store[2][5:0], store[1][7:3]};
    assign eraw[2] = {store[4][0], store[3], store[2][7:6]};
    assign eraw[3] = {store[5][3:0], store[4][7:1]};
    assign ech4    = {store[17], store[16]} - 16'd1024;
    assign sw1     = store[5][5:4];
    assign sw2     = store[5][7:6];

    always_comb begin
        ext_err = (sw1 == 2'd0) || (sw2 == 2'd0);
        for (int i = 0; i < 4; i++) begin
            ech[i] = {1'b0, eraw[i]} - 12'd1024;
            if (chan_mag(ech[i]) > cfg.ext_limit) begin
                ext_err = 1'b1;
            end
        end
    end

    // Assemble the item list for the selected format
    always_comb begin
        dec = '0;
        if (is_sbus) begin
            dec.fmt   = FMT_SBUS;
            dec.err   = sbus_err;
            dec.count = REM_SBUS;
            for (int i = 0; i < SBUS_RESULTS; i++) begin
                dec.id[i]    = ID_W'(i);
                dec.value[i] = sext12(sch[i]);
            end
            for (int i = 0; i < 4; i++) begin
                if (sbus_err || (sbus_mag[i] < cfg.deadband)) begin
                    dec.value[i] = '0;
                end
            end
            if (sbus_err) begin
                dec.value[4] = '0;
            end
        end else begin
            dec.fmt   = FMT_EXT;
            dec.err   = ext_err;
            dec.count = REM_EXT;
            for (int i = 0; i < MAX_RESULTS; i++) begin
                dec.id[i] = (i < 5) ? ID_W'(i) : ID_W'(i + 5);
            end
            if (ext_err) begin
                dec.value[5] = value_t'(2);
                dec.value[6] = value_t'(2);
            end else begin
                for (int i = 0; i < 4; i++) begin
                    dec.value[i] = sext12(ech[i]);
                end
                dec.value[4]  = sext16(ech4);
                dec.value[5]  = {15'd0, sw1};
                dec.value[6]  = {15'd0, sw2};
                dec.value[7]  = sext16({store[7], store[6]});
                dec.value[8]  = sext16({store[9], store[8]});
                dec.value[9]  = sext16({store[11], store[10]});
                dec.value[10] = {9'd0, store[12]};
                dec.value[11] = {9'd0, store[13]};
                dec.value[12] = {1'b0, store[15], store[14]};
            end
        end
    end

endmodule

`default_nettype wire

// ===== design/rcfd_emit.sv =====
// Result emitter: holds one decoded frame and shifts its items out.
`default_nettype none

module rcfd_emit (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  done,
    input  rcfd_pkg::decoded_t    dec,
    output logic                  idle,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [23:0]           m_tdata,
    output logic [6:0]            m_tuser,
    output logic                  m_tlast
);
    import rcfd_pkg::*;

    value_t [MAX_RESULTS-1:0]           val_reg;
    logic   [MAX_RESULTS-1:0][ID_W-1:0] id_reg;
    logic                               fmt_reg;
    logic                               err_reg;
    logic   [REM_W-1:0]                 rem_reg;
    logic   [REM_W-1:0]                 rem_next;
    logic                               load;
    logic                               take;

    assign idle = (rem_reg == '0);
    assign load = done && idle;
    assign take = m_tvalid && m_tready;

    always_comb begin
        rem_next = rem_reg;
        if (load) begin
            rem_next = dec.count;
        end else if (take) begin
            rem_next = rem_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rem_reg <= '0;
        end else begin
            rem_reg <= rem_next;
        end
    end

    // Load a decoded frame, or advance the item list by one per transaction
    always_ff @(posedge aclk) begin
        if (load) begin
            val_reg <= dec.value;
            id_reg  <= dec.id;
            fmt_reg <= dec.fmt;
            err_reg <= dec.err;
        end else if (take) begin
            for (int i = 0; i < MAX_RESULTS - 1; i++) begin
                val_reg[i] <= val_reg[i+1];
                id_reg[i]  <= id_reg[i+1];
            end
        end
    end

    assign m_tvalid = !idle;
    assign m_tdata  = {7'd0, val_reg[0]};
    assign m_tuser  = {err_reg, fmt_reg, id_reg[0]};
    assign m_tlast  = (rem_reg == REM_W'(1));

`ifndef SYNTHESIS
    a_load_count: assert property (@(posedge aclk) disable iff (!aresetn)
        load |=> (rem_reg == REM_SBUS || rem_reg == REM_EXT))
        else $error("emitter loaded with a bad item count");

    a_last_empties: assert property (@(posedge aclk) disable iff (!aresetn)
        (take && m_tlast) |=> (rem_reg == '0))
        else $error("items left after the final transaction");

    a_sbus_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && err_reg && (fmt_reg == FMT_SBUS) && (id_reg[0] <= ID_SBUS_ZERO_LAST))
        |-> (val_reg[0] == '0))
        else $error("SBUS error frame with a nonzero stick channel");

    a_ext_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && err_reg && (fmt_reg == FMT_EXT) &&
         (id_reg[0] != ID_SWITCH_1) && (id_reg[0] != ID_SWITCH_2))
        |-> (val_reg[0] == '0))
        else $error("error frame with a nonzero item");
`endif

endmodule

`default_nettype wire

// ===== design/rc_receiver_frame_decoder.sv =====
// After the edge that accepts a frame's last byte, the frame-complete flag is registered; with the
// result stage empty, the emitter then loads its item count register and m_tvalid rises.
// Throughput: one byte per cycle while s_tready is high; results leave one per cycle from a shift
// register while m_tready is high (10 for SBUS, 13 for the 18-byte format), as the next frame's
// bytes keep arriving. Input stalls only if a frame completes while the previous frame's results
// are still held. Reset (aresetn, synchronous, active low) clears the byte count and pending flags
// and loads the configuration registers with their defaults; the frame store is not cleared.
`default_nettype none

module rc_receiver_frame_decoder (
    input  logic                            aclk,
    input  logic                            aresetn,
    // Input stream
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [7:0]                      s_tdata,   // [7:0] rx_byte
    input  logic                            s_tlast,   // frame_end
    // Result stream
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [23:0]                     m_tdata,   // [16:0] value, rest zero
    output logic [6:0]                      m_tuser,   // [4:0] item_id, [5] format, [6] frame_error
    output logic                            m_tlast,   // last
    // Configuration writes
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [rcfd_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [rcfd_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import rcfd_pkg::*;

    cfg_t        cfg;
    store_t      store;
    frame_done_t done;
    decoded_t    dec;
    logic        emit_idle;

    assign cfg_ready = 1'b1;

    rcfd_cfg_regs u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (cfg_valid && cfg_ready),
        .wr_addr (cfg_addr),
        .wr_data (cfg_wdata),
        .cfg     (cfg)
    );

    rcfd_capture u_capture (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_valid     (s_tvalid),
        .in_ready     (s_tready),
        .in_byte      (s_tdata),
        .in_end       (s_tlast),
        .frame_length (cfg.frame_length),
        .emit_idle    (emit_idle),
        .store        (store),
        .done         (done)
    );

    rcfd_decode u_decode (
        .store    (store),
        .sbus_len (done.sbus_len),
        .cfg      (cfg),
        .dec      (dec)
    );

    rcfd_emit u_emit (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .done     (done.valid),
        .dec      (dec),
        .idle     (emit_idle),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

`default_nettype wire

// ===== verif/rcfd_result_checker.sv =====
// Result checker for the receiver frame decoder: predicts decoded items and compares them.
module rcfd_result_checker (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic [7:0]                      s_tdata,   // [7:0] rx_byte
    input  logic                            s_tlast,   // frame_end
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [23:0]                     m_tdata,   // [16:0] value, rest zero
    input  logic [6:0]                      m_tuser,   // [4:0] item_id, [5] format, [6] frame_error
    input  logic                            m_tlast,   // last
    input  logic                            cfg_valid,
    input  logic                            cfg_ready,
    input  logic [rcfd_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [rcfd_pkg::CFG_DATA_W-1:0] cfg_wdata,
    output int                              fail_count,
    output int                              pending_count
);
    timeunit 1ns;
    timeprecision 1ps;

    import rcfd_pkg::*;

    localparam int RST_FRAME_LENGTH = 25;
    localparam int RST_DEADBAND     = 30;
    localparam int RST_SBUS_LIMIT   = 1024;
    localparam int RST_EXT_LIMIT    = 660;
    localparam int STICK_CENTER     = 1024;
    localparam int AUX_CENTER       = 240;
    localparam int MAX_PRINTED      = 40;

    typedef struct {
        logic [ID_W-1:0] id;
        value_t          value;
        logic            fmt;
        logic            err;
        logic            last;
    } decoded_item_t;

    decoded_item_t expected_items[$];
    logic [7:0]    rx_store[STORE_DEPTH];
    int            rx_count;
    int            frame_len;
    int            deadband;
    int            sbus_lim;
    int            ext_lim;
    int            printed;

    initial printed = 0;

    function automatic int magnitude(int v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic int wrap16(int u);
        int w;
        w = u & 'hFFFF;
        return (w & 'h8000) ? w - 65536 : w;
    endfunction

    function automatic void push_item(int id, int val, logic fmt, logic err, logic last);
        decoded_item_t r;
        r.id    = ID_W'(id);
        r.value = value_t'(val);
        r.fmt   = fmt;
        r.err   = err;
        r.last  = last;
        expected_items.push_back(r);
    endfunction

    // Unpack ten 11-bit channels, then apply the stick limit and the deadband
    function automatic void decode_sbus_frame();
        int   b[16];
        int   ch[10];
        int   i;
        logic err;
        for (i = 0; i < 16; i++) b[i] = int'(rx_store[i]);
        ch[0] = (b[1] | (b[2] << 8)) & 'h7FF;
        ch[1] = ((b[2] >> 3) | (b[3] << 5)) & 'h7FF;
        ch[2] = ((b[3] >> 6) | (b[4] << 2) | (b[5] << 10)) & 'h7FF;
        ch[3] = ((b[5] >> 1) | (b[6] << 7)) & 'h7FF;
        ch[4] = ((b[6] >> 4) | (b[7] << 4)) & 'h7FF;
        ch[5] = ((b[7] >> 7) | (b[8] << 1) | (b[9] << 9)) & 'h7FF;
        ch[6] = ((b[9] >> 2) | (b[10] << 6)) & 'h7FF;
        ch[7] = ((b[10] >> 5) | (b[11] << 3)) & 'h7FF;
        ch[8] = (b[12] | (b[13] << 8)) & 'h7FF;
        ch[9] = ((b[13] >> 3) | (b[14] << 5)) & 'h7FF;
        for (i = 0; i < 4; i++) ch[i] -= STICK_CENTER;
        for (i = 4; i < 10; i++) ch[i] -= AUX_CENTER;
        err = 1'b0;
        for (i = 0; i < 4; i++) begin
            if (magnitude(ch[i]) > sbus_lim) err = 1'b1;
        end
        if (err) begin
            for (i = 0; i < 5; i++) ch[i] = 0;
        end else begin
            for (i = 0; i < 4; i++) begin
                if (magnitude(ch[i]) < deadband) ch[i] = 0;
            end
        end
        for (i = 0; i < SBUS_RESULTS; i++) begin
            push_item(i, ch[i], FMT_SBUS, err, i == SBUS_RESULTS - 1);
        end
    endfunction

    // Unpack sticks, switches, mouse, buttons and keys of the 18-byte format
    function automatic void decode_ext_frame();
        int   b[18];
        int   v[MAX_RESULTS];
        int   i;
        logic err;
        for (i = 0; i < 18; i++) b[i] = int'(rx_store[i]);
        v[0]  = ((b[0] | (b[1] << 8)) & 'h7FF) - STICK_CENTER;
        v[1]  = (((b[1] >> 3) | (b[2] << 5)) & 'h7FF) - STICK_CENTER;
        v[2]  = (((b[2] >> 6) | (b[3] << 2) | (b[4] << 10)) & 'h7FF) - STICK_CENTER;
        v[3]  = (((b[4] >> 1) | (b[5] << 7)) & 'h7FF) - STICK_CENTER;
        v[4]  = wrap16((b[16] | (b[17] << 8)) + 'h10000 - STICK_CENTER);
        v[5]  = (b[5] >> 4) & 'h3;
        v[6]  = ((b[5] >> 4) & 'hC) >> 2;
        v[7]  = wrap16(b[6] | (b[7] << 8));
        v[8]  = wrap16(b[8] | (b[9] << 8));
        v[9]  = wrap16(b[10] | (b[11] << 8));
        v[10] = b[12];
        v[11] = b[13];
        v[12] = b[14] | (b[15] << 8);
        err = 1'b0;
        for (i = 0; i < 4; i++) begin
            if (magnitude(v[i]) > ext_lim) err = 1'b1;
        end
        if (v[5] == 0 || v[6] == 0) err = 1'b1;
        // On error every item reads zero except the switches, which read middle position
        if (err) begin
            for (i = 0; i < MAX_RESULTS; i++) v[i] = 0;
            v[5] = 2;
            v[6] = 2;
        end
        for (i = 0; i < MAX_RESULTS; i++) begin
            push_item((i < 5) ? i : i + 5, v[i], FMT_EXT, err, i == MAX_RESULTS - 1);
        end
    endfunction

    task automatic report_mismatch(input string what);
        if (printed < MAX_PRINTED) $display("%0t ERROR: %s", $time, what);
        printed++;
        fail_count++;
    endtask

    // Track every transaction on the three channels at the rising edge
    always @(posedge aclk) begin
        int            len;
        decoded_item_t exp_item;
        if (!aresetn) begin
            expected_items.delete();
            rx_count   = 0;
            frame_len  = RST_FRAME_LENGTH;
            deadband   = RST_DEADBAND;
            sbus_lim   = RST_SBUS_LIMIT;
            ext_lim    = RST_EXT_LIMIT;
            fail_count = 0;
        end else begin
            // Update the register copy
            if (cfg_valid && cfg_ready) begin
                case (cfg_addr)
                    REG_FRAME_LENGTH: frame_len = int'(cfg_wdata[COUNT_W-1:0]);
                    REG_DEADBAND:     deadband  = int'(cfg_wdata);
                    REG_SBUS_LIMIT:   sbus_lim  = int'(cfg_wdata);
                    REG_EXT_LIMIT:    ext_lim   = int'(cfg_wdata);
                    default: ;
                endcase
            end
            // Store the byte, count it, and decode on the frame end
            if (s_tvalid && s_tready) begin
                if (rx_count < STORE_DEPTH) rx_store[rx_count] = s_tdata;
                if (rx_count < int'(COUNT_MAX)) rx_count++;
                if (s_tlast) begin
                    len      = rx_count;
                    rx_count = 0;
                    if (len == frame_len && len <= MAX_FRAME_BYTES) begin
                        if (len == int'(SBUS_LEN) && rx_store[0] == SBUS_HEAD &&
                            rx_store[STORE_DEPTH-1] == SBUS_TAIL) begin
                            decode_sbus_frame();
                        end else begin
                            decode_ext_frame();
                        end
                    end
                end
            end
            // Compare each result with the oldest prediction
            if (m_tvalid && m_tready) begin
                if (expected_items.size() == 0) begin
                    report_mismatch($sformatf("result id %0d with nothing expected",
                                              m_tuser[4:0]));
                end else begin
                    exp_item = expected_items.pop_front();
                    if (m_tuser[4:0] != exp_item.id)
                        report_mismatch($sformatf("item_id got %0d expected %0d",
                                                  m_tuser[4:0], exp_item.id));
                    if (m_tdata[VALUE_W-1:0] != exp_item.value)
                        report_mismatch($sformatf("id %0d value got %0d expected %0d",
                                                  exp_item.id, $signed(m_tdata[VALUE_W-1:0]),
                                                  exp_item.value));
                    if (m_tuser[5] != exp_item.fmt)
                        report_mismatch($sformatf("id %0d format got %0b expected %0b",
                                                  exp_item.id, m_tuser[5], exp_item.fmt));
                    if (m_tuser[6] != exp_item.err)
                        report_mismatch($sformatf("id %0d frame_error got %0b expected %0b",
                                                  exp_item.id, m_tuser[6], exp_item.err));
                    if (m_tlast != exp_item.last)
                        report_mismatch($sformatf("id %0d last got %0b expected %0b",
                                                  exp_item.id, m_tlast, exp_item.last));
                end
            end
        end
        pending_count = expected_items.size();
    end

endmodule

// ===== verif/tb_rc_receiver_frame_decoder.sv =====
// Testbench top for the receiver frame decoder: clock, reset, stimulus and verdict.
module tb_rc_receiver_frame_decoder;
    timeunit 1ns;
    timeprecision 1ps;

    import rcfd_pkg::*;

    localparam int CYCLE_LIMIT      = 50000;
    localparam int LONG_HOLD_CYCLES = 600;
    localparam int IDLE_SETTLE      = 4;
    localparam int DRAIN_CYCLES     = 20;
    localparam int RANDOM_PHASES    = 4;
    localparam int MIN_FRAME_LEN    = 18;
    localparam int STICK_CENTER     = 1024;
    localparam int AUX_CENTER       = 240;

    logic                  aclk;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [7:0]            s_tdata   = '0;
    logic                  s_tlast   = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [23:0]           m_tdata;
    logic [6:0]            m_tuser;
    logic                  m_tlast;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    int          fail_count;
    int          pending_count;
    int unsigned cycle_count    = 0;
    int          send_idle_pct  = 0;
    int          recv_stall_pct = 0;
    logic        hold_request   = 1'b0;

    // Current register values, used to aim the stimulus at the boundaries
    int cur_len      = 25;
    int cur_deadband = 30;
    int cur_sbus_lim = 1024;
    int cur_ext_lim  = 660;

    logic [7:0]  frame_bytes[$];
    logic [10:0] stick_raw[10];

    rc_receiver_frame_decoder u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    rcfd_result_checker u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tlast       (s_tlast),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser),
        .m_tlast       (m_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    always @(posedge aclk) cycle_count <= cycle_count + 1;

    // Abort a hung run
    initial begin
        while (cycle_count < CYCLE_LIMIT) @(posedge aclk);
        $display("TEST FAILED");
        $finish;
    end

    // Result receiver: random stalls, plus one long hold-off on request
    initial begin
        int hold_left;
        hold_left = 0;
        forever begin
            @(negedge aclk);
            if (hold_request) begin
                hold_request = 1'b0;
                hold_left    = LONG_HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                m_tready <= 1'b0;
                hold_left--;
            end else begin
                m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
            end
        end
    end

    function automatic logic [7:0] rand_byte();
        return 8'($urandom_range(0, 255));
    endfunction

    // Stick raw value around center: inside a band, on the limit, just past it, or anywhere
    function automatic logic [10:0] pick_stick(int lim, int band);
        int v;
        case ($urandom_range(0, 15))
            11:      v = STICK_CENTER + lim;
            12:      v = STICK_CENTER - lim;
            13:      v = STICK_CENTER + lim + 1;
            14:      v = STICK_CENTER - lim - 1;
            15:      v = $urandom_range(0, 2047);
            default: v = STICK_CENTER - band + int'($urandom_range(0, 2 * band));
        endcase
        if (v < 0) v = 0;
        if (v > 2047) v = 2047;
        return v[10:0];
    endfunction

    function automatic logic [1:0] pick_switch();
        return ($urandom_range(0, 7) == 0) ? 2'd0 : 2'($urandom_range(1, 3));
    endfunction

    // Register value: an extreme, something near the interesting point, or anywhere
    function automatic int pick_setting(int top, int near_lo, int near_hi);
        case ($urandom_range(0, 5))
            0:       return 0;
            1:       return top;
            2, 3:    return $urandom_range(near_lo, near_hi);
            default: return $urandom_range(0, top);
        endcase
    endfunction

    function automatic void center_sticks();
        int i;
        for (i = 0; i < 10; i++) stick_raw[i] = (i < 4) ? 11'(STICK_CENTER) : 11'(AUX_CENTER);
    endfunction

    function automatic void random_sticks();
        int i;
        for (i = 0; i < 10; i++) begin
            stick_raw[i] = (i < 4) ? pick_stick(cur_sbus_lim, cur_deadband + 8)
                                   : 11'($urandom_range(0, 2047));
        end
    endfunction

    // SBUS frame: header, ten packed channels, filler, zero end byte
    function automatic void build_sbus_frame();
        logic [111:0] bits;
        int           k;
        bits = '0;
        for (k = 0; k < 10; k++) bits[11*k +: 11] = stick_raw[k];
        frame_bytes.delete();
        frame_bytes.push_back(SBUS_HEAD);
        for (k = 0; k < 14; k++) frame_bytes.push_back(bits[8*k +: 8]);
        for (k = 15; k < STORE_DEPTH - 1; k++) frame_bytes.push_back(rand_byte());
        frame_bytes.push_back(SBUS_TAIL);
    endfunction

    // 18-byte format: four packed sticks, switches in the upper nibble of byte 5
    function automatic void build_ext_frame(int len, logic [1:0] sw1, logic [1:0] sw2);
        logic [43:0] bits;
        int          k;
        for (k = 0; k < 4; k++) bits[11*k +: 11] = stick_raw[k];
        frame_bytes.delete();
        for (k = 0; k < 5; k++) frame_bytes.push_back(bits[8*k +: 8]);
        frame_bytes.push_back({sw2, sw1, bits[43:40]});
        for (k = 6; k < len; k++) frame_bytes.push_back(rand_byte());
    endfunction

    // 18-byte format at the current length, sticks aimed at the current limit
    function automatic void build_random_ext();
        int i;
        random_sticks();
        for (i = 0; i < 4; i++) stick_raw[i] = pick_stick(cur_ext_lim, 40);
        build_ext_frame(cur_len, pick_switch(), pick_switch());
    endfunction

    function automatic void build_filled(int len, logic [7:0] val);
        int k;
        frame_bytes.delete();
        for (k = 0; k < len; k++) frame_bytes.push_back(val);
    endfunction

    function automatic void build_noise(int len);
        int k;
        frame_bytes.delete();
        for (k = 0; k < len; k++) frame_bytes.push_back(rand_byte());
    endfunction

    // Offer one byte after a random gap and hold it until accepted
    task automatic send_byte(input logic [7:0] b, input logic last);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
    endtask

    // Send the built frame, then deassert s_tvalid
    task automatic send_frame();
        int i;
        for (i = 0; i < frame_bytes.size(); i++) begin
            send_byte(frame_bytes[i], i == frame_bytes.size() - 1);
        end
        s_tvalid <= 1'b0;
        @(negedge aclk);
    endtask

    // Wait until every result has left, then let a frame without results settle
    task automatic wait_idle();
        while (pending_count != 0) @(negedge aclk);
        repeat (IDLE_SETTLE) @(negedge aclk);
    endtask

    // Write one register and hold it until accepted
    task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr, input int data);
        cfg_valid <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= CFG_DATA_W'(data);
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        @(negedge aclk);
    endtask

    // Write all four registers back to back while the block is idle
    task automatic apply_config(input int fl, input int db, input int sl, input int el);
        wait_idle();
        write_reg(REG_FRAME_LENGTH, fl);
        write_reg(REG_DEADBAND, db);
        write_reg(REG_SBUS_LIMIT, sl);
        write_reg(REG_EXT_LIMIT, el);
        cfg_valid    <= 1'b0;
        cur_len      = fl;
        cur_deadband = db;
        cur_sbus_lim = sl;
        cur_ext_lim  = el;
    endtask

    task automatic set_idling(input int mode);
        case (mode)
            0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1:       begin send_idle_pct = 88; recv_stall_pct = 0;  end
            2:       begin send_idle_pct = 0;  recv_stall_pct = 88; end
            default: begin send_idle_pct = 9;  recv_stall_pct = 9;  end
        endcase
    endtask

    // Mostly well-formed frames with random content; the rest noise and bad lengths
    task automatic random_frame();
        int kind;
        int len;
        kind = $urandom_range(0, 99);
        if (kind < 35 && cur_len == int'(SBUS_LEN)) begin
            random_sticks();
            build_sbus_frame();
        end else if (kind < 70) begin
            build_random_ext();
        end else if (kind < 80) begin
            build_noise(cur_len);
        end else if (kind < 95) begin
            len = $urandom_range(1, 40);
            if (len == cur_len) len = cur_len + 1;
            build_noise(len);
        end else begin
            build_noise($urandom_range(60, 70));
        end
        send_frame();
    endtask

    initial begin
        int p;
        int f;

        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        set_idling(0);

        // Sticks just inside and on the deadband edge, aux channels at both ends
        center_sticks();
        stick_raw[0] = 11'(STICK_CENTER + 29);
        stick_raw[1] = 11'(STICK_CENTER - 29);
        stick_raw[2] = 11'(STICK_CENTER + 30);
        stick_raw[3] = 11'(STICK_CENTER - 30);
        stick_raw[4] = 11'd0;
        stick_raw[5] = 11'h7FF;
        stick_raw[9] = 11'h7FF;
        build_sbus_frame();
        send_frame();

        // Short frame of the wrong length: no results
        build_noise(4);
        send_frame();

        // SBUS length but wrong end byte: decoded in the other format
        random_sticks();
        build_sbus_frame();
        frame_bytes[STORE_DEPTH-1] = 8'h80;
        send_frame();

        // Shortest frame, widest stick limit: all-ones content passes unchanged
        apply_config(MIN_FRAME_LEN, 0, 0, 2047);
        build_filled(MIN_FRAME_LEN, 8'hFF);
        send_frame();

        // Random phases, one per idling mode
        for (p = 0; p < RANDOM_PHASES; p++) begin
            apply_config((p == 1) ? int'(SBUS_LEN) :
                         ((p == 3) ? int'($urandom_range(MIN_FRAME_LEN, MAX_FRAME_BYTES))
                                   : MIN_FRAME_LEN),
                         pick_setting(1024, 0, 60),
                         pick_setting(2047, 900, 1100),
                         pick_setting(2047, 600, 700));
            set_idling(p);
            if (p == 0) begin
                // Hold results off: two frames fill the block, the third stalls at the input
                hold_request = 1'b1;
                for (f = 0; f < 2; f++) begin
                    build_random_ext();
                    send_frame();
                end
                build_noise(3);
                send_frame();
            end else if (p == 1) begin
                random_sticks();
                build_sbus_frame();
                send_frame();
            end else begin
                random_frame();
            end
        end

        // Drain the remaining results, then give the verdict
        set_idling(0);
        while (pending_count != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
